/* src/tbjc_pkg.sv */
// Shared widths, latencies and types for the three-body Jacobi cosine block.
package tbjc_pkg;

	// Widest vector component entering a cosine lane: w = p*m - p*m.
	localparam int VW = 41;
	// Block-normalized components stay below 2^NLIM in magnitude.
	localparam int NLIM = 20;
	localparam int CW = NLIM + 1;
	localparam int SW = 5;
	// Products, dot product and sums of squares after normalization.
	localparam int PW = 2 * CW;
	localparam int DW = PW + 2;
	localparam int QW = 2 * NLIM + 2;
	localparam int RW = QW / 2;
	localparam int DENW = 2 * RW;
	// Quotient bits and remainder width of the rounding divider.
	localparam int QB = 18;
	localparam int FRAC = 15;
	localparam int RMW = DW + FRAC + 1;
	// Momentum magnitude path.
	localparam int PIW = 24;
	localparam int MW = 2 * PIW;
	localparam int MRW = MW / 2;
	localparam int MASSW = 16;
	localparam int COSW = 16;

	// Latency of a cosine lane: front, normalize, products, sums,
	// square roots, scale, numerator, divide, saturate.
	localparam int COS_LAT = 5 + RW + 2 + QB + 1;
	localparam int MAG_CORE = 2 + MRW;
	localparam int MAG_DLY = COS_LAT - MAG_CORE;

	localparam logic [QB-1:0] Q_POS_LIM = QB'(32767);
	localparam logic [QB-1:0] Q_NEG_LIM = QB'(32768);
	localparam logic signed [COSW-1:0] COS_POS_SAT = 16'sh7fff;
	localparam logic signed [COSW-1:0] COS_NEG_SAT = 16'sh8000;

	typedef logic signed [VW-1:0] comp_t;

	// Result of one cosine lane toward the merge stage.
	typedef struct packed {
		logic                   zero;
		logic signed [COSW-1:0] cosv;
	} lane_res_t;

endpackage

/* src/tbjc_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module tbjc_isqrt #(
	parameter int W = 42
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   rad,
	output logic [W/2-1:0] root
);

	localparam int K = W / 2;

	logic [W-1:0] n_q [K];
	logic [W-1:0] r_q [K];

	// One digit per stage, highest pair of bits first
	for (genvar k = 0; k < K; k++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
		logic [W-1:0] n_in, r_in, trial;

		if (k == 0) begin : g_first
			assign n_in = rad;
			assign r_in = '0;
		end else begin : g_next
			assign n_in = n_q[k-1];
			assign r_in = r_q[k-1];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (n_in >= trial) begin
					n_q[k] <= n_in - trial;
					r_q[k] <= (r_in >> 1) + BIT;
				end else begin
					n_q[k] <= n_in;
					r_q[k] <= r_in >> 1;
				end
			end
		end
	end

	assign root = r_q[K-1][K-1:0];

endmodule

/* src/tbjc_mag_lane.sv */
// Momentum magnitude lane: sum of squares, square root, latency match.
module tbjc_mag_lane (
	input  logic                      clk,
	input  logic                      en,
	input  tbjc_pkg::comp_t           p [3],
	output logic [tbjc_pkg::MRW-1:0]  mag
);

	import tbjc_pkg::*;

	logic [PIW-1:0] am_c [3];
	logic [MW-1:0]  sq_s1 [3];
	logic [MW-1:0]  sum_s2;
	logic [MRW-1:0] root;
	logic [MRW-1:0] dl_q [MAG_DLY];

	// Component magnitudes fit the input width
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			am_c[k] = p[k][VW-1] ? PIW'(-p[k]) : PIW'(p[k]);
		end
	end

	// Squares, then their sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s1[k] <= am_c[k] * am_c[k];
			end
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	tbjc_isqrt #(.W(MW)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s2),
		.root (root)
	);

	// Delay to line up with the cosine lanes
	always_ff @(posedge clk) begin
		if (en) begin
			dl_q[0] <= root;
			for (int i = 1; i < MAG_DLY; i++) begin
				dl_q[i] <= dl_q[i-1];
			end
		end
	end

	assign mag = dl_q[MAG_DLY-1];

endmodule

/* src/tbjc_cos_lane.sv */
// Cosine lane: normalize two vectors, dot product, norms, rounded divide.
module tbjc_cos_lane (
	input  logic                clk,
	input  logic                en,
	input  logic                neg,
	input  tbjc_pkg::comp_t     a [3],
	input  tbjc_pkg::comp_t     b [3],
	output tbjc_pkg::lane_res_t res
);

	import tbjc_pkg::*;

	function automatic logic [SW-1:0] shift_of(input logic [VW-1:0] m);
		logic [SW-1:0] s;
		s = '0;
		for (int i = NLIM; i < VW; i++) begin
			if (m[i]) s = SW'(i + 1 - NLIM);
		end
		return s;
	endfunction

	logic [VW-1:0]          amag_c [3], bmag_c [3];
	logic [VW-1:0]          amax_c, bmax_c;
	logic [VW-1:0]          amag_s1 [3], bmag_s1 [3];
	logic                   asgn_s1 [3], bsgn_s1 [3];
	logic [VW-1:0]          amax_s1, bmax_s1;
	logic [VW-1:0]          amag_s2 [3], bmag_s2 [3];
	logic                   asgn_s2 [3], bsgn_s2 [3];
	logic [SW-1:0]          ash_s2, bsh_s2;
	logic                   zf_s2;
	logic signed [CW-1:0]   an_s3 [3], bn_s3 [3];
	logic signed [PW-1:0]   pab_s4 [3], paa_s4 [3], pbb_s4 [3];
	logic signed [DW-1:0]   dsum_c;
	logic signed [DW-1:0]   dot_s5;
	logic [QW-1:0]          sa_s5, sb_s5;
	logic [RW-1:0]          ra, rb;
	logic signed [DW-1:0]   dot_dl [RW];
	logic [DENW-1:0]        den_s27;
	logic [DW-1:0]          dmag_s27;
	logic                   dneg_s27;
	logic [RMW-1:0]         num_s28;
	logic [DENW-1:0]        den_s28;
	logic                   dneg_s28;
	logic [RMW-1:0]         rem_q [QB];
	logic [DENW-1:0]        den_q [QB];
	logic [QB-1:0]          qt_q [QB];
	logic                   neg_q [QB];
	logic                   zl_q [COS_LAT-3];
	lane_res_t              res_q;

	// Stage 1: magnitudes, signs and largest component of each vector
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			amag_c[k] = a[k][VW-1] ? VW'(-a[k]) : VW'(a[k]);
			bmag_c[k] = b[k][VW-1] ? VW'(-b[k]) : VW'(b[k]);
		end
		amax_c = amag_c[0];
		bmax_c = bmag_c[0];
		for (int k = 1; k < 3; k++) begin
			if (amag_c[k] > amax_c) amax_c = amag_c[k];
			if (bmag_c[k] > bmax_c) bmax_c = bmag_c[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				amag_s1[k] <= amag_c[k];
				bmag_s1[k] <= bmag_c[k];
				asgn_s1[k] <= a[k][VW-1];
				bsgn_s1[k] <= b[k][VW-1];
			end
			amax_s1 <= amax_c;
			bmax_s1 <= bmax_c;
		end
	end

	// Stage 2: block shift counts and zero-length detect
	always_ff @(posedge clk) begin
		if (en) begin
			amag_s2 <= amag_s1;
			bmag_s2 <= bmag_s1;
			asgn_s2 <= asgn_s1;
			bsgn_s2 <= bsgn_s1;
			ash_s2  <= shift_of(amax_s1);
			bsh_s2  <= shift_of(bmax_s1);
			zf_s2   <= (amax_s1 == '0) || (bmax_s1 == '0);
		end
	end

	// Stage 3: shift and restore signs (truncation toward zero)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				an_s3[k] <= asgn_s2[k] ?
					-$signed({1'b0, NLIM'(amag_s2[k] >> ash_s2)}) :
					$signed({1'b0, NLIM'(amag_s2[k] >> ash_s2)});
				bn_s3[k] <= bsgn_s2[k] ?
					-$signed({1'b0, NLIM'(bmag_s2[k] >> bsh_s2)}) :
					$signed({1'b0, NLIM'(bmag_s2[k] >> bsh_s2)});
			end
		end
	end

	// Stage 4: nine products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pab_s4[k] <= an_s3[k] * bn_s3[k];
				paa_s4[k] <= an_s3[k] * an_s3[k];
				pbb_s4[k] <= bn_s3[k] * bn_s3[k];
			end
		end
	end

	// Stage 5: dot product (negated for the Y cosines) and squared norms
	assign dsum_c = DW'(pab_s4[0]) + DW'(pab_s4[1]) + DW'(pab_s4[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s5 <= neg ? -dsum_c : dsum_c;
			sa_s5  <= QW'(DW'(paa_s4[0]) + DW'(paa_s4[1]) + DW'(paa_s4[2]));
			sb_s5  <= QW'(DW'(pbb_s4[0]) + DW'(pbb_s4[1]) + DW'(pbb_s4[2]));
		end
	end

	tbjc_isqrt #(.W(QW)) u_sqrt_a (
		.clk  (clk),
		.en   (en),
		.rad  (sa_s5),
		.root (ra)
	);

	tbjc_isqrt #(.W(QW)) u_sqrt_b (
		.clk  (clk),
		.en   (en),
		.rad  (sb_s5),
		.root (rb)
	);

	// Dot product waits alongside the square roots
	always_ff @(posedge clk) begin
		if (en) begin
			dot_dl[0] <= dot_s5;
			for (int i = 1; i < RW; i++) begin
				dot_dl[i] <= dot_dl[i-1];
			end
		end
	end

	// Stage 27: denominator, dot magnitude and sign
	always_ff @(posedge clk) begin
		if (en) begin
			den_s27  <= ra * rb;
			dneg_s27 <= dot_dl[RW-1][DW-1];
			dmag_s27 <= dot_dl[RW-1][DW-1] ? DW'(-dot_dl[RW-1]) : DW'(dot_dl[RW-1]);
		end
	end

	// Stage 28: rounded numerator
	always_ff @(posedge clk) begin
		if (en) begin
			num_s28  <= (RMW'(dmag_s27) << FRAC) + RMW'(den_s27 >> 1);
			den_s28  <= den_s27;
			dneg_s28 <= dneg_s27;
		end
	end

	// Restoring divider, one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int SH = QB - 1 - k;
		logic [RMW-1:0]  rem_in, dsh;
		logic [DENW-1:0] den_in;
		logic [QB-1:0]   qt_in;
		logic            neg_in;

		if (k == 0) begin : g_first
			assign rem_in = num_s28;
			assign den_in = den_s28;
			assign qt_in  = '0;
			assign neg_in = dneg_s28;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign qt_in  = qt_q[k-1];
			assign neg_in = neg_q[k-1];
		end

		assign dsh = RMW'(den_in) << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[k] <= den_in;
				neg_q[k] <= neg_in;
				if (rem_in >= dsh) begin
					rem_q[k] <= rem_in - dsh;
					qt_q[k]  <= qt_in | (QB'(1) << SH);
				end else begin
					rem_q[k] <= rem_in;
					qt_q[k]  <= qt_in;
				end
			end
		end
	end

	// Zero-length flag follows the item to the last divider stage
	always_ff @(posedge clk) begin
		if (en) begin
			zl_q[0] <= zf_s2;
			for (int i = 1; i < COS_LAT - 3; i++) begin
				zl_q[i] <= zl_q[i-1];
			end
		end
	end

	// Final stage: saturate to Q1.15, force zero on a degenerate pair
	always_ff @(posedge clk) begin
		if (en) begin
			res_q.zero <= zl_q[COS_LAT-4];
			if (zl_q[COS_LAT-4]) begin
				res_q.cosv <= '0;
			end else if (neg_q[QB-1]) begin
				res_q.cosv <= (qt_q[QB-1] >= Q_NEG_LIM) ? COS_NEG_SAT :
					$signed(COSW'(~qt_q[QB-1] + 1'b1));
			end else begin
				res_q.cosv <= (qt_q[QB-1] >= Q_POS_LIM) ? COS_POS_SAT :
					$signed(qt_q[QB-1][COSW-1:0]);
			end
		end
	end

	assign res = res_q;

	a_zero_forces_zero: assert property (@(posedge clk)
		res_q.zero |-> (res_q.cosv == '0))
		else $error("degenerate lane result is not zero");

endmodule

/* src/three_body_jacobi_cosines.sv */
// Top level: input unpack, difference stage, lanes, merge and output register.
//
// Three-fragment Jacobi cosines. One event enters on the s_ stream channel:
// three 24-bit momentum vectors and three 16-bit masses. One result leaves on
// the m_ stream channel: four Q1.15 cosines (T, Y first, Y second, V), three
// momentum magnitudes, and a degenerate flag in m_tuser.
// A request is taken when tvalid and tready are both high.
// Throughput: one event per cycle, fully pipelined, as long as no finished
// result is blocked by the receiver. An accepted event loads the difference
// stage, then passes 47 lane stages (set by the 21-stage square roots and the
// 18-stage divider) and the output register.
// Four cosine lanes and three magnitude lanes run side by side; the output
// register merges their results and ORs the lane zero flags.
// When the receiver stalls, the pipeline keeps taking events until its last
// stage holds a result that cannot move; empty slots still advance.
// Reset clears the valid bits of every stage and the output register; data
// registers are not reset.
module three_body_jacobi_cosines (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_px, first_py, first_pz, second_px, second_py, second_pz,
	// third_px, third_py, third_pz, first_mass, second_mass, third_mass
	input  logic [263:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cos_t, cos_y_first, cos_y_second, cos_v, mag_first, mag_second,
	// mag_third
	output logic [135:0] m_tdata,
	// degenerate
	output logic         m_tuser
);

	import tbjc_pkg::*;

	logic                   en;
	logic [COS_LAT:0]       v_q;
	logic signed [PIW-1:0]  p_in [3][3];
	logic [MASSW-1:0]       m_in [3];
	logic signed [VW-1:0]   w0_c [3], w1_c [3];
	comp_t                  p_s1 [3][3];
	comp_t                  d_s1 [3], w0_s1 [3], w1_s1 [3];
	lane_res_t              lr [4];
	logic [MRW-1:0]         mag [3];
	logic                   out_valid_q;
	logic [135:0]           out_data_q;
	logic                   out_deg_q;

	// Field unpack
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				p_in[i][k] = $signed(s_tdata[(i*3+k)*PIW +: PIW]);
			end
			m_in[i] = s_tdata[9*PIW + i*MASSW +: MASSW];
		end
	end

	// Pipeline advances unless a finished result is blocked
	assign en = !v_q[COS_LAT] || !out_valid_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[COS_LAT-1:0], s_tvalid};
		end
	end

	// Cross-multiplied velocity differences
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			w0_c[k] = p_in[0][k] * $signed({1'b0, m_in[2]})
				- p_in[2][k] * $signed({1'b0, m_in[0]});
			w1_c[k] = p_in[1][k] * $signed({1'b0, m_in[2]})
				- p_in[2][k] * $signed({1'b0, m_in[1]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					p_s1[i][k] <= VW'(p_in[i][k]);
				end
				d_s1[k]  <= VW'(p_in[0][k]) - VW'(p_in[1][k]);
				w0_s1[k] <= w0_c[k];
				w1_s1[k] <= w1_c[k];
			end
		end
	end

	// Cosine lanes: T, Y first, Y second, V
	tbjc_cos_lane u_lane_t (
		.clk (clk), .en (en), .neg (1'b0),
		.a (d_s1), .b (p_s1[2]), .res (lr[0])
	);

	tbjc_cos_lane u_lane_y0 (
		.clk (clk), .en (en), .neg (1'b1),
		.a (w0_s1), .b (p_s1[1]), .res (lr[1])
	);

	tbjc_cos_lane u_lane_y1 (
		.clk (clk), .en (en), .neg (1'b1),
		.a (w1_s1), .b (p_s1[0]), .res (lr[2])
	);

	tbjc_cos_lane u_lane_v (
		.clk (clk), .en (en), .neg (1'b0),
		.a (w0_s1), .b (w1_s1), .res (lr[3])
	);

	// Magnitude lanes
	for (genvar i = 0; i < 3; i++) begin : g_mag
		tbjc_mag_lane u_mag (
			.clk (clk), .en (en), .p (p_s1[i]), .mag (mag[i])
		);
	end

	// Merge stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && v_q[COS_LAT]) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_q[COS_LAT]) begin
			out_data_q <= {mag[2], mag[1], mag[0],
				lr[3].cosv, lr[2].cosv, lr[1].cosv, lr[0].cosv};
			out_deg_q  <= lr[0].zero | lr[1].zero | lr[2].zero | lr[3].zero;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_deg_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a blocked result");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !v_q[COS_LAT]) |=> !m_tvalid)
		else $error("result shown twice");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[COS_LAT] && en) |=> m_tvalid)
		else $error("finished result lost");

endmodule
